>>> rtl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types and codes of the buffer pool frame manager.
// Holds configuration indexes, request codes, sequencer states and the result record layout.
// ----------------------------------------------------------------------------
package bpfm_pkg;

    localparam int ID_W = 31;

    // Configuration register indexes.
    localparam logic [0:0] CFG_COUNT  = 1'b0;
    localparam logic [0:0] CFG_NUMBER = 1'b1;

    typedef enum logic [2:0] {
        REQ_FETCH  = 3'd0,
        REQ_NEW    = 3'd1,
        REQ_UNPIN  = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_FLUSH  = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_VICT,
        ST_LRU_SCAN,
        ST_LRU_SHIFT,
        ST_APPEND,
        ST_OUT
    } state_t;

    // Result item, packed in field order.
    typedef struct packed {
        logic            disk_write;
        logic            disk_read;
        logic [ID_W-1:0] evict_page_id;
        logic            evict_write;
        logic [ID_W-1:0] assigned_page_id;
        logic [3:0]      frame_index;
        logic            ok;
    } result_t;

endpackage

>>> rtl/buffer_pool_frame_manager_core.sv
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_core: page frame bookkeeping with LRU eviction.
// Serves fetch, new page, unpin, delete and flush requests, one at a time.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: req_type[2:0], page_id[33:3], mark_dirty[34]
// m_axis    out  tdata: ok, frame_index, assigned_page_id, evict_write,
//                       evict_page_id, disk_read, disk_write
// cfg       in   cfg_wr_en, cfg_index (0 instance_count, 1 instance_number)
//
// An item runs a frame lookup scan over the frame memory, plus up to two
// passes over the LRU memory (scan then shift) when a frame leaves or joins
// the LRU order. The free stack is initialized by a pass over its entries
// after reset, during which no item is accepted. A stalled result holds only
// the output register; the next item is taken once it has been delivered.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_core #(
    parameter int POOL_FRAMES = 16,
    parameter int PIN_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // req_type, page_id, mark_dirty
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // ok, frame_index, assigned_page_id,
                                        // evict_write, evict_page_id,
                                        // disk_read, disk_write
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);
    import bpfm_pkg::*;

    localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam logic [CW-1:0] FULL = CW'(POOL_FRAMES);
    localparam logic [PIN_BITS-1:0] PMAX = '1;
    localparam logic [PIN_BITS-1:0] PONE = PIN_BITS'(1);

    state_t state_reg, state_next;

    // Request registers.
    logic [2:0]      req_reg;
    logic [ID_W-1:0] pid_reg;
    logic            mark_reg;
    result_t         res_reg, res_next;
    logic            mvalid_reg, mvalid_next;

    // Bookkeeping registers.
    logic [CW-1:0]   free_cnt_reg, free_cnt_next;
    logic [CW-1:0]   lru_cnt_reg, lru_cnt_next;
    logic [ID_W-1:0] next_page_reg;
    logic [4:0]      inst_cnt_reg;
    logic            init_reg;
    logic [CW-1:0]   init_cnt_reg;

    // Scan registers.
    logic [CW-1:0]   idx_reg, idx_next;       // address issued
    logic            rv_reg, rv_next;         // read data pending
    logic [FW-1:0]   ridx_reg, ridx_next;     // address of read data
    logic            hit_reg, hit_next;
    logic [FW-1:0]   hf_reg, hf_next;         // frame of interest
    logic [PIN_BITS-1:0] hpins_reg, hpins_next;
    logic            hdirty_reg, hdirty_next;
    logic [ID_W-1:0] hpage_reg, hpage_next;
    logic            hvalid_reg, hvalid_next;
    logic            append_reg, append_next; // append hf after removal

    // Memory ports.
    logic [FW-1:0]   fm_raddr;
    logic            fm_rvalid, fm_rdirty;
    logic [ID_W-1:0] fm_rpage;
    logic [PIN_BITS-1:0] fm_rpins;
    logic            fm_we, fm_wvalid, fm_wdirty;
    logic [FW-1:0]   fm_waddr;
    logic [ID_W-1:0] fm_wpage;
    logic [PIN_BITS-1:0] fm_wpins;

    logic            fs_we, lr_we;
    logic [FW-1:0]   fs_waddr, fs_wdata, fs_raddr, fs_rdata;
    logic [FW-1:0]   lr_waddr, lr_wdata, lr_raddr, lr_rdata;

    logic            s_fire;
    logic [ID_W-1:0] in_pid;

    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) & !init_reg & !mvalid_reg;
    assign in_pid        = s_axis_tdata[33:3];

    bpfm_frame_mem #(.FRAMES(POOL_FRAMES), .PINW(PIN_BITS), .FW(FW)) u_frames (
        .aclk(aclk), .aresetn(aresetn),
        .rd_addr(fm_raddr), .rd_valid(fm_rvalid), .rd_page(fm_rpage),
        .rd_pins(fm_rpins), .rd_dirty(fm_rdirty),
        .wr_en(fm_we), .wr_addr(fm_waddr), .wr_valid(fm_wvalid),
        .wr_page(fm_wpage), .wr_pins(fm_wpins), .wr_dirty(fm_wdirty)
    );

    bpfm_list_mem #(.FRAMES(POOL_FRAMES), .FW(FW)) u_free (
        .aclk(aclk), .wr_en(fs_we), .wr_addr(fs_waddr), .wr_data(fs_wdata),
        .rd_addr(fs_raddr), .rd_data(fs_rdata)
    );

    bpfm_list_mem #(.FRAMES(POOL_FRAMES), .FW(FW)) u_lru (
        .aclk(aclk), .wr_en(lr_we), .wr_addr(lr_waddr), .wr_data(lr_wdata),
        .rd_addr(lr_raddr), .rd_data(lr_rdata)
    );

    // Configuration, init pass and next page id.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inst_cnt_reg  <= 5'd1;
            next_page_reg <= '0;
            init_reg      <= 1'b1;
            init_cnt_reg  <= '0;
        end else begin
            if (init_reg) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
                if (init_cnt_reg == FULL - 1'b1) begin
                    init_reg <= 1'b0;
                end
            end
            if (cfg_wr_en && cfg_index == CFG_COUNT) begin
                inst_cnt_reg <= cfg_wdata;
            end else if (cfg_wr_en) begin
                next_page_reg <= ID_W'(cfg_wdata[3:0]);
            end else if (state_reg == ST_VICT && hvalid_reg &&
                         req_reg == REQ_NEW) begin
                next_page_reg <= next_page_reg + ID_W'(inst_cnt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg  <= s_axis_tdata[2:0];
            pid_reg  <= in_pid;
            mark_reg <= s_axis_tdata[34];
        end
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        ridx_reg   <= ridx_next;
        hf_reg     <= hf_next;
        hpins_reg  <= hpins_next;
        hdirty_reg <= hdirty_next;
        hpage_reg  <= hpage_next;
        hvalid_reg <= hvalid_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mvalid_reg   <= 1'b0;
            free_cnt_reg <= FULL;
            lru_cnt_reg  <= '0;
            rv_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            append_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mvalid_reg   <= mvalid_next;
            free_cnt_reg <= free_cnt_next;
            lru_cnt_reg  <= lru_cnt_next;
            rv_reg       <= rv_next;
            hit_reg      <= hit_next;
            append_reg   <= append_next;
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        mvalid_next   = mvalid_reg;
        free_cnt_next = free_cnt_reg;
        lru_cnt_next  = lru_cnt_reg;
        idx_next      = idx_reg;
        rv_next       = 1'b0;
        ridx_next     = idx_reg[FW-1:0];
        hit_next      = hit_reg;
        hf_next       = hf_reg;
        hpins_next    = hpins_reg;
        hdirty_next   = hdirty_reg;
        hpage_next    = hpage_reg;
        hvalid_next   = hvalid_reg;
        append_next   = append_reg;

        fm_raddr  = idx_reg[FW-1:0];
        fm_we     = 1'b0;
        fm_waddr  = hf_reg;
        fm_wvalid = 1'b1;
        fm_wpage  = hpage_reg;
        fm_wpins  = hpins_reg;
        fm_wdirty = hdirty_reg;
        fs_we     = init_reg;
        fs_waddr  = init_cnt_reg[FW-1:0];
        fs_wdata  = init_cnt_reg[FW-1:0];
        fs_raddr  = FW'(free_cnt_reg - 1'b1);
        lr_we     = 1'b0;
        lr_waddr  = idx_reg[FW-1:0];
        lr_wdata  = lr_rdata;
        lr_raddr  = idx_reg[FW-1:0];

        if (mvalid_reg && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    append_next = 1'b0;
                    res_next    = '0;
                    state_next  = ST_LOOK;
                end
            end
            // Scan frames for the lowest matching valid entry.
            ST_LOOK: begin
                if (idx_reg < FULL) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg && !hit_reg && fm_rvalid && fm_rpage == pid_reg) begin
                    hit_next    = 1'b1;
                    hf_next     = ridx_reg;
                    hpins_next  = fm_rpins;
                    hdirty_next = fm_rdirty;
                end
                if (idx_reg == FULL && !rv_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_OUT;
                hpage_next = pid_reg;
                case (req_reg)
                    REQ_FETCH, REQ_NEW: begin
                        if (req_reg == REQ_FETCH && hit_reg) begin
                            if (hpins_reg != PMAX) begin
                                res_next.ok          = 1'b1;
                                res_next.frame_index = 4'(hf_reg);
                                fm_we    = 1'b1;
                                fm_wpage = pid_reg;
                                fm_wpins = hpins_reg + 1'b1;
                                if (hpins_reg == '0) begin
                                    idx_next   = '0;
                                    rv_next    = 1'b0;
                                    state_next = ST_LRU_SCAN;
                                end
                            end
                        end else if (free_cnt_reg != '0) begin
                            free_cnt_next = free_cnt_reg - 1'b1;
                            hf_next       = fs_rdata;
                            state_next    = ST_VICT;
                            hvalid_next   = 1'b0;
                        end else if (lru_cnt_reg != '0) begin
                            hf_next    = lr_rdata;
                            state_next = ST_VICT;
                            idx_next   = '0;
                            hvalid_next = 1'b0;
                        end
                        if (req_reg == REQ_NEW) begin
                            hpage_next = next_page_reg;
                        end
                    end
                    REQ_UNPIN: begin
                        if (hit_reg && hpins_reg != '0) begin
                            res_next.ok          = 1'b1;
                            res_next.frame_index = 4'(hf_reg);
                            fm_we     = 1'b1;
                            fm_wpage  = pid_reg;
                            fm_wpins  = hpins_reg - 1'b1;
                            fm_wdirty = hdirty_reg | mark_reg;
                            if (hpins_reg == PONE) begin
                                append_next = 1'b1;
                                idx_next    = '0;
                                state_next  = ST_LRU_SCAN;
                            end
                        end
                    end
                    REQ_DELETE: begin
                        if (!hit_reg) begin
                            res_next.ok = 1'b1;
                        end else if (hpins_reg == '0) begin
                            res_next.ok          = 1'b1;
                            res_next.frame_index = 4'(hf_reg);
                            fm_we     = 1'b1;
                            fm_wvalid = 1'b0;
                            fm_wdirty = 1'b0;
                            if (free_cnt_reg < FULL) begin
                                fs_we         = 1'b1;
                                fs_waddr      = free_cnt_reg[FW-1:0];
                                fs_wdata      = hf_reg;
                                free_cnt_next = free_cnt_reg + 1'b1;
                            end
                            idx_next   = '0;
                            state_next = ST_LRU_SCAN;
                        end
                    end
                    REQ_FLUSH: begin
                        if (hit_reg) begin
                            res_next.ok          = 1'b1;
                            res_next.frame_index = 4'(hf_reg);
                            res_next.disk_write  = 1'b1;
                            fm_we     = 1'b1;
                            fm_wpage  = pid_reg;
                            fm_wdirty = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Read the chosen frame's record (victim or free frame).
            ST_VICT: begin
                fm_raddr = hf_reg;
                if (!hvalid_reg) begin
                    hvalid_next = 1'b1;
                end else begin
                    res_next.ok          = 1'b1;
                    res_next.frame_index = 4'(hf_reg);
                    res_next.disk_read   = (req_reg == REQ_FETCH);
                    res_next.disk_write  = (req_reg == REQ_NEW);
                    if (req_reg == REQ_NEW) begin
                        res_next.assigned_page_id = hpage_reg;
                    end
                    if (fm_rdirty) begin
                        res_next.evict_write   = 1'b1;
                        res_next.evict_page_id = fm_rpage;
                    end
                    fm_we     = 1'b1;
                    fm_wpins  = PONE;
                    fm_wdirty = 1'b0;
                    if (free_cnt_reg == free_cnt_next && lru_cnt_reg != '0 &&
                        res_reg.ok == 1'b0 && hvalid_reg && idx_reg == '0 &&
                        free_cnt_reg == '0) begin
                        idx_next   = '0;
                        state_next = ST_LRU_SCAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            // Find hf in the LRU order.
            ST_LRU_SCAN: begin
                if (idx_reg < lru_cnt_reg) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg && lr_rdata == hf_reg) begin
                    idx_next   = CW'(ridx_reg) + 1'b1;
                    rv_next    = 1'b0;
                    state_next = ST_LRU_SHIFT;
                end else if (idx_reg >= lru_cnt_reg && !rv_reg) begin
                    state_next = append_reg ? ST_APPEND : ST_OUT;
                end
            end
            // Move later entries down by one.
            ST_LRU_SHIFT: begin
                if (idx_reg < lru_cnt_reg && !rv_reg) begin
                    rv_next  = 1'b1;
                    idx_next = idx_reg;
                end else if (rv_reg) begin
                    lr_we    = 1'b1;
                    lr_waddr = FW'(idx_reg - 1'b1);
                    idx_next = idx_reg + 1'b1;
                end else begin
                    lru_cnt_next = lru_cnt_reg - 1'b1;
                    state_next   = append_reg ? ST_APPEND : ST_OUT;
                end
            end
            ST_APPEND: begin
                if (lru_cnt_reg < FULL) begin
                    lr_we        = 1'b1;
                    lr_waddr     = lru_cnt_reg[FW-1:0];
                    lr_wdata     = hf_reg;
                    lru_cnt_next = lru_cnt_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // Keep the LRU head ready for a victim choice.
        if (state_reg == ST_IDLE || state_reg == ST_LOOK) begin
            lr_raddr = '0;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {2'b00, res_reg};

endmodule

>>> rtl/bpfm_frame_mem.sv
// ----------------------------------------------------------------------------
// bpfm_frame_mem: frame metadata memory.
// One synchronous memory holding page id, pin count and dirty bit per frame,
// with a valid bit per frame in flip-flops that reset clears.
// ----------------------------------------------------------------------------
module bpfm_frame_mem #(
    parameter int FRAMES = 16,
    parameter int PINW   = 16,
    parameter int FW     = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [FW-1:0]            rd_addr,
    output logic                     rd_valid,
    output logic [bpfm_pkg::ID_W-1:0] rd_page,
    output logic [PINW-1:0]          rd_pins,
    output logic                     rd_dirty,
    input  logic                     wr_en,
    input  logic [FW-1:0]            wr_addr,
    input  logic                     wr_valid,
    input  logic [bpfm_pkg::ID_W-1:0] wr_page,
    input  logic [PINW-1:0]          wr_pins,
    input  logic                     wr_dirty
);
    import bpfm_pkg::*;

    localparam int RW = ID_W + PINW + 1;

    logic [RW-1:0]     mem [FRAMES];
    logic [RW-1:0]     rdata_reg;
    logic [FRAMES-1:0] valid_reg;
    logic              rvalid_reg;

    // Record storage with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_page, wr_pins, wr_dirty};
        end
        rdata_reg <= mem[rd_addr];
    end

    // Valid bits; an invalid frame reads as clean and unpinned.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= wr_valid;
            end
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid = rvalid_reg;
    assign rd_page  = rdata_reg[RW-1 -: ID_W];
    assign rd_pins  = rvalid_reg ? rdata_reg[PINW:1] : '0;
    assign rd_dirty = rvalid_reg & rdata_reg[0];

endmodule

>>> rtl/bpfm_list_mem.sv
// ----------------------------------------------------------------------------
// bpfm_list_mem: small frame-number memory.
// Used for both the free stack and the LRU order: one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bpfm_list_mem #(
    parameter int FRAMES = 16,
    parameter int FW     = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [FW-1:0] wr_addr,
    input  logic [FW-1:0] wr_data,
    input  logic [FW-1:0] rd_addr,
    output logic [FW-1:0] rd_data
);
    logic [FW-1:0] mem [FRAMES];
    logic [FW-1:0] rdata_reg;

    // Storage with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rd_data = rdata_reg;

endmodule

>>> rtl/bpfm_checker.sv
// ----------------------------------------------------------------------------
// bpfm_checker: port-level checks of the frame manager.
// Watches the stream and result fields over time.
// ----------------------------------------------------------------------------
module bpfm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A failed request reports no frame and no transfer.
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[70:1] == '0)
        else $error("failed result carries fields");

    // Read and write flags never come together.
    a_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[68] && m_axis_tdata[69]))
        else $error("read and write flags both set");

    // No input is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

endmodule

bind buffer_pool_frame_manager_core bpfm_checker u_chk (.*);
